### rtl/core/sensor_mask_note_event_deframer_defines.svh
// ----------------------------------------------------------------------------
// Sensor mask note event deframer: assertion macros
// Shared concurrent assertion forms used by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_MASK_NOTE_EVENT_DEFRAMER_DEFINES_SVH
`define SENSOR_MASK_NOTE_EVENT_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SMNED_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMNED_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/smned_pkg.sv
// ----------------------------------------------------------------------------
// Sensor mask note event deframer package
// Word layouts, opcodes, sync phases and link constants.
// ----------------------------------------------------------------------------
`default_nettype none

package smned_pkg;

  // Stream word widths, padded to whole bytes.
  localparam int IN_W  = 40;
  localparam int OUT_W = 24;

  // Sync pair on the serial link.
  localparam logic [7:0] SYNC_FIRST  = 8'hFE;
  localparam logic [7:0] SYNC_SECOND = 8'hED;

  typedef enum logic [1:0] {
    OP_SERIAL = 2'd0,
    OP_NOTE   = 2'd1,
    OP_OFFSET = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_DEVICE = 4'b0100,
    PH_MASK   = 4'b1000
  } phase_t;

  // One note table entry.
  typedef struct packed {
    logic       holdable;
    logic [6:0] velocity;
    logic [6:0] pitch;
  } note_entry_t;

  // Input word, first field in the lowest bits.
  typedef struct packed {
    logic       pad;
    logic [7:0] offset_value;
    logic       entry_holdable;
    logic [6:0] entry_velocity;
    logic [6:0] entry_pitch;
    logic [2:0] target_sensor;
    logic [2:0] target_device;
    logic [7:0] serial_byte;
    logic [1:0] opcode;
  } in_word_t;

  // Output word, first field in the lowest bits.
  typedef struct packed {
    logic [3:0] pad;
    logic [6:0] velocity;
    logic [6:0] pitch;
    logic [2:0] sensor_index;
    logic [2:0] channel;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/core/smned_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module smned_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/sensor_mask_note_event_deframer.sv
// ----------------------------------------------------------------------------
// Sensor mask note event deframer
// Hunts FE ED sync on a byte stream and turns sensor mask changes into notes.
// ----------------------------------------------------------------------------
// Each input word is a link byte, a note table write or a device offset write.
// Link bytes are taken one per cycle unless the input stalls. A mask byte
// for a device in range starts the event engine: stage A reads the stored
// mask and offset, then the note table read port walks the changed sensors
// one per cycle while stage B can move on, giving one event per cycle when
// the output is free. While the engine is busy, sync and device bytes of
// the next packet are still taken; the next mask byte and table or offset
// writes wait until it has drained. Results pass through a hold register
// and an output register, so the engine keeps running while one result
// waits to be taken and stalls once both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_mask_note_event_deframer_defines.svh"

module sensor_mask_note_event_deframer #(
  parameter int DEVICE_COUNT = 8,
  parameter int SENSOR_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // opcode, serial_byte, target_device, target_sensor, entry_pitch,
  // entry_velocity, entry_holdable, offset_value, zero fill
  input  logic [smned_pkg::IN_W-1:0]   s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // channel, sensor_index, pitch, velocity, zero fill
  output logic [smned_pkg::OUT_W-1:0]  m_tdata,
  // note_on
  output logic                         m_tuser,
  output logic                         m_tlast
);

  import smned_pkg::*;

  localparam int DEV_W    = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int NT_DEPTH = DEVICE_COUNT * SENSOR_COUNT;
  localparam int NT_AW    = (NT_DEPTH > 1) ? $clog2(NT_DEPTH) : 1;
  localparam logic [8:0] DEV_LIMIT = 9'(DEVICE_COUNT);
  localparam logic [3:0] SEN_LIMIT = 4'(SENSOR_COUNT);
  localparam logic [7:0] SENS_MASK = 8'((9'd1 << SENSOR_COUNT) - 9'd1);

  // Input word decode.
  in_word_t   in_w;
  opcode_t    op;
  logic       accept;
  logic       stall;
  logic       busy;

  assign in_w   = in_word_t'(s_tdata);
  assign op     = opcode_t'(in_w.opcode);
  assign accept = s_tvalid && s_tready;

  // Sync state.
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] pending_device;
  logic [8:0] pend_ext;
  logic [DEV_W-1:0] pend_idx;
  logic       start_pkt;

  // Side write decode.
  logic [8:0]  tdev_ext;
  logic [DEV_W-1:0] tdev_idx;
  logic        tdev_ok;
  logic        tsen_ok;
  logic [11:0] nt_waddr_full;
  logic        nt_we;
  logic        off_we;
  note_entry_t nt_wdata;

  // Stage A: mask and offset read in flight.
  logic             a_valid;
  logic [7:0]       a_mask;
  logic [DEV_W-1:0] a_dev;
  logic [2:0]       a_chan;
  logic             a_mask_seen;
  logic             a_off_seen;
  logic [DEVICE_COUNT-1:0] mask_seen;
  logic [DEVICE_COUNT-1:0] off_seen;
  logic [7:0]       mask_rdata;
  logic [7:0]       off_rdata;
  logic [7:0]       prev_mask;

  // Sensor scanner.
  logic [7:0]       scan_remain;
  logic [7:0]       scan_mask;
  logic [DEV_W-1:0] scan_dev;
  logic [2:0]       scan_chan;
  logic [7:0]       scan_offset;
  logic [2:0]       pick;
  logic [7:0]       remain_after;
  logic             issue;
  logic [11:0]      nt_raddr_full;

  // Stage B: note entry read in flight.
  logic        b_valid;
  logic [2:0]  b_sensor;
  logic        b_on;
  logic        b_final;
  note_entry_t nt_rdata;
  logic [9:0]  vel_sum;
  logic [6:0]  vel_sat;
  logic        cand;
  logic        b_push;
  logic        b_go;
  out_word_t   cand_word;

  // Hold register that keeps one event back to mark the last one.
  logic        h_valid;
  logic        h_final;
  logic        h_on;
  out_word_t   h_word;
  logic        h_push;
  logic        out_free;

  // Engine activity and input interlock.
  assign busy  = a_valid || (scan_remain != 8'd0) || b_valid || h_valid;
  assign stall = busy && ((op == OP_NOTE) || (op == OP_OFFSET) ||
                          ((op == OP_SERIAL) && (phase == PH_MASK)));
  assign s_tready = !stall;

  // Sync phase transitions.
  always_comb begin
    phase_next = phase;
    if (accept && (op == OP_SERIAL)) begin
      unique case (phase)
        PH_HUNT: begin
          if (in_w.serial_byte == SYNC_FIRST) phase_next = PH_SECOND;
        end
        PH_SECOND: begin
          if (in_w.serial_byte == SYNC_SECOND) begin
            phase_next = PH_DEVICE;
          end else if (in_w.serial_byte != SYNC_FIRST) begin
            phase_next = PH_HUNT;
          end
        end
        PH_DEVICE: phase_next = PH_MASK;
        PH_MASK:   phase_next = PH_HUNT;
        default:   phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      pending_device <= 8'd0;
    end else begin
      phase <= phase_next;
      if (accept && (op == OP_SERIAL) && (phase == PH_DEVICE)) begin
        pending_device <= in_w.serial_byte;
      end
    end
  end

  assign pend_ext  = {1'b0, pending_device};
  assign pend_idx  = pend_ext[DEV_W-1:0];
  assign start_pkt = accept && (op == OP_SERIAL) && (phase == PH_MASK) &&
                     (pend_ext < DEV_LIMIT);

  // Note table and offset write decode.
  assign tdev_ext      = {6'd0, in_w.target_device};
  assign tdev_idx      = tdev_ext[DEV_W-1:0];
  assign tdev_ok       = tdev_ext < DEV_LIMIT;
  assign tsen_ok       = {1'b0, in_w.target_sensor} < SEN_LIMIT;
  assign nt_waddr_full = 12'(in_w.target_device) * 12'(SENSOR_COUNT) +
                         12'(in_w.target_sensor);
  assign nt_we         = accept && (op == OP_NOTE) && tdev_ok && tsen_ok;
  assign off_we        = accept && (op == OP_OFFSET) && tdev_ok;
  assign nt_wdata      = '{holdable: in_w.entry_holdable,
                           velocity: in_w.entry_velocity,
                           pitch:    in_w.entry_pitch};

  // Stored masks per device; written back once the old mask is known.
  smned_ram #(.WIDTH(8), .DEPTH(DEVICE_COUNT)) u_mask_ram (
    .clk   (clk),
    .we    (a_valid),
    .waddr (a_dev),
    .wdata (a_mask),
    .re    (start_pkt),
    .raddr (pend_idx),
    .rdata (mask_rdata)
  );

  // Velocity offsets per device.
  smned_ram #(.WIDTH(8), .DEPTH(DEVICE_COUNT)) u_offset_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (tdev_idx),
    .wdata (in_w.offset_value),
    .re    (start_pkt),
    .raddr (pend_idx),
    .rdata (off_rdata)
  );

  // Pitch, velocity and holdable flag per device and sensor.
  smned_ram #(.WIDTH($bits(note_entry_t)), .DEPTH(NT_DEPTH)) u_note_ram (
    .clk   (clk),
    .we    (nt_we),
    .waddr (nt_waddr_full[NT_AW-1:0]),
    .wdata (nt_wdata),
    .re    (issue),
    .raddr (nt_raddr_full[NT_AW-1:0]),
    .rdata (nt_rdata)
  );

  // Written flags stand in for the all-zero reset of masks and offsets.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_seen <= '0;
      off_seen  <= '0;
    end else begin
      if (a_valid) mask_seen[a_dev] <= 1'b1;
      if (off_we)  off_seen[tdev_idx] <= 1'b1;
    end
  end

  // Stage A registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start_pkt;
    end
    if (start_pkt) begin
      a_mask      <= in_w.serial_byte;
      a_dev       <= pend_idx;
      a_chan      <= pending_device[2:0];
      a_mask_seen <= mask_seen[pend_idx];
      a_off_seen  <= off_seen[pend_idx];
    end
  end

  assign prev_mask = a_mask_seen ? mask_rdata : 8'd0;

  // Lowest changed sensor still to be reported.
  always_comb begin
    pick = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (scan_remain[i]) pick = 3'(i);
    end
  end

  assign remain_after  = scan_remain & (scan_remain - 8'd1);
  assign issue         = (scan_remain != 8'd0) && (!b_valid || b_go);
  assign nt_raddr_full = 12'(scan_dev) * 12'(SENSOR_COUNT) + 12'(pick);

  // Scanner: load the changed bits, then retire one per note read.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_remain <= 8'd0;
    end else if (a_valid) begin
      scan_remain <= (a_mask ^ prev_mask) & SENS_MASK;
    end else if (issue) begin
      scan_remain <= remain_after;
    end
    if (a_valid) begin
      scan_mask   <= a_mask;
      scan_dev    <= a_dev;
      scan_chan   <= a_chan;
      scan_offset <= a_off_seen ? off_rdata : 8'd0;
    end
  end

  // Stage B registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
    if (issue) begin
      b_sensor <= pick;
      b_on     <= scan_mask[pick];
      b_final  <= (remain_after == 8'd0);
    end
  end

  // Velocity plus signed offset, clamped to 0..127.
  assign vel_sum = {3'b000, nt_rdata.velocity} + {{2{scan_offset[7]}}, scan_offset};
  always_comb begin
    if (vel_sum[9]) begin
      vel_sat = 7'd0;
    end else if (vel_sum[8:7] != 2'd0) begin
      vel_sat = 7'h7F;
    end else begin
      vel_sat = vel_sum[6:0];
    end
  end

  // Event candidate from the note entry; a release of a plain note gives none.
  assign cand      = b_on || nt_rdata.holdable;
  assign cand_word = '{pad:          4'd0,
                       velocity:     b_on ? vel_sat : 7'd0,
                       pitch:        nt_rdata.pitch,
                       sensor_index: b_sensor,
                       channel:      scan_chan};

  assign out_free = !m_tvalid || m_tready;
  assign b_push   = b_valid && cand && h_valid;
  assign b_go     = b_valid && (!b_push || out_free);
  assign h_push   = h_valid && h_final && out_free;

  // Hold register: a new event pushes the held one out as not last.
  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      h_final <= 1'b0;
    end else begin
      priority if (b_go && cand) begin
        h_valid <= 1'b1;
        h_final <= b_final;
      end else if (b_go && b_final) begin
        h_final <= h_valid;
      end else if (h_push) begin
        h_valid <= 1'b0;
        h_final <= 1'b0;
      end
    end
    if (b_go && cand) begin
      h_on   <= b_on;
      h_word <= cand_word;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((b_go && b_push) || h_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if ((b_go && b_push) || h_push) begin
      m_tdata <= h_word;
      m_tuser <= h_on;
      m_tlast <= h_push;
    end
  end

  // Engine checks.
  `SMNED_ASSERT_NOW(a_engine_empty_at_load, clk, rst, a_valid,
    (scan_remain == 8'd0) && !b_valid && !h_valid,
    "mask load while the event engine still holds a packet")
  `SMNED_ASSERT_NOW(a_final_read_drains_scan, clk, rst, b_valid && b_final,
    scan_remain == 8'd0, "sensors left after the final note read")
  `SMNED_ASSERT_NOW(a_no_final_hold_with_read, clk, rst, b_valid,
    !(h_valid && h_final), "held last event while a note read is pending")
  `SMNED_ASSERT_NEXT(a_start_on_idle_engine, clk, rst, start_pkt,
    !b_valid && !h_valid, "packet started while earlier events were pending")

endmodule

`default_nettype wire
